FILE: src/npps_pkg.sv
// shared types and constants for the nearest point patch search block
package npps_pkg;

   localparam int ID_W    = 32;
   localparam int POS_W   = 20;
   localparam int DIFF_W  = POS_W + 1;
   localparam int CNT_W   = 11;
   localparam int DSQ_W   = 42;
   localparam int DIST_W  = 21;
   localparam int FRAC_W  = 16;
   localparam int REM_W   = DIST_W + 3;
   localparam int STEP_W  = 5;
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = 1;
   localparam int QCNT_W  = 2;

   // item kinds
   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_CAND  = 1'b1;

   // result status codes
   localparam logic ST_FOUND     = 1'b0;
   localparam logic ST_NOT_FOUND = 1'b1;

   localparam logic [DSQ_W-1:0] DSQ_ONES = {DSQ_W{1'b1}};

   // one finished query handed from front to back
   typedef struct packed {
      logic [ID_W-1:0]  query_id;
      logic [ID_W-1:0]  best_node;
      logic [DSQ_W-1:0] dist_sq;
      logic             not_found;
      logic [CNT_W-1:0] best_index;
      logic [CNT_W-1:0] count;
   } job_type;

   // one result word
   typedef struct packed {
      logic [ID_W-1:0]   query_id;
      logic [ID_W-1:0]   nearest_id;
      logic [DIST_W-1:0] distance;
      logic              status;
      logic [FRAC_W-1:0] max_fraction;
   } res_type;

endpackage

FILE: src/nearest_point_patch_search.sv
// top level of the nearest point patch search block
// after the last candidate word is taken, it passes the difference, square and compare
// states of the front, the job queue, the root digit steps of the back and the result register;
// an empty patch skips the root digit steps
// the front takes no new word until the last one has passed compare; the back works on one job at a time
// reset clears the query, best tracking, running maximum, job queue and result valid
module nearest_point_patch_search import npps_pkg::*; #(
   parameter int MAX_PATCH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // node_id, pos_x, pos_y, pos_z, patch_count, zero pad
   input  logic         req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // query_id, nearest_id, distance, status, max_fraction, pad
);

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   job_type pop_job;
   res_type rsp_res;

   npps_front #(
      .MAX_PATCH(MAX_PATCH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_kind        (req_tuser),
      .req_node_id     (req_tdata[31:0]),
      .req_pos_x       (req_tdata[51:32]),
      .req_pos_y       (req_tdata[71:52]),
      .req_pos_z       (req_tdata[91:72]),
      .req_patch_count (req_tdata[102:92]),
      .push_valid      (push_valid),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   npps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_job  (pop_job)
   );

   npps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_res     (rsp_res)
   );

   // result word packing, first field lowest
   assign rsp_tdata = {2'b00, rsp_res.max_fraction, rsp_res.status, rsp_res.distance,
                       rsp_res.nearest_id, rsp_res.query_id};

endmodule

FILE: src/npps_front.sv
// front end: takes query and candidate words, tracks the nearest candidate
module npps_front import npps_pkg::*; #(
   parameter int MAX_PATCH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [ID_W-1:0]  req_node_id,
   input  logic [POS_W-1:0] req_pos_x,
   input  logic [POS_W-1:0] req_pos_y,
   input  logic [POS_W-1:0] req_pos_z,
   input  logic [CNT_W-1:0] req_patch_count,
   output logic             push_valid,
   output job_type          push_job,
   input  logic             queue_full
);

   localparam int CAP_MAX = (1 << CNT_W) - 1;
   localparam int CAP     = (MAX_PATCH < CAP_MAX) ? MAX_PATCH : CAP_MAX;
   localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_CMP  = 3'b100
   } fstate_type;

   fstate_type        state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [DSQ_W-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;

   logic [ID_W-1:0]   qnode_ff, qnode_in;
   logic [POS_W-1:0]  qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic [CNT_W-1:0]  exp_ff, exp_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [DSQ_W-1:0]  best_sq_ff, best_sq_in;
   logic [ID_W-1:0]   best_node_ff, best_node_in;
   logic [CNT_W-1:0]  best_idx_ff, best_idx_in;

   logic [DIFF_W-1:0] ax, ay, az;
   logic [DSQ_W-1:0]  d_sum;
   logic [CNT_W-1:0]  cnt_sat;
   logic [CNT_W-1:0]  seen_nx;
   logic              active;
   logic              better;
   logic              push_want;
   logic [DSQ_W-1:0]  nb_sq;
   logic [ID_W-1:0]   nb_node;
   logic [CNT_W-1:0]  nb_idx;

   // magnitudes of the coordinate differences
   assign ax = dx_ff[DIFF_W-1] ? (~dx_ff + DIFF_W'(1)) : dx_ff;
   assign ay = dy_ff[DIFF_W-1] ? (~dy_ff + DIFF_W'(1)) : dy_ff;
   assign az = dz_ff[DIFF_W-1] ? (~dz_ff + DIFF_W'(1)) : dz_ff;

   // compare stage arithmetic
   assign d_sum   = sqx_ff + sqy_ff + sqz_ff;
   assign cnt_sat = (cnt_ff > CAP_V) ? CAP_V : cnt_ff;
   assign active  = seen_ff < exp_ff;
   assign better  = d_sum < best_sq_ff;
   assign seen_nx = seen_ff + CNT_W'(1);
   assign nb_sq   = better ? d_sum : best_sq_ff;
   assign nb_node = better ? id_ff : best_node_ff;
   assign nb_idx  = better ? seen_ff : best_idx_ff;

   assign req_ready = (state_ff == F_IDLE);

   // sequencing of one word through difference, square and compare
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      cnt_in       = cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      sqz_in       = sqz_ff;
      qnode_in     = qnode_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      exp_in       = exp_ff;
      seen_in      = seen_ff;
      best_sq_in   = best_sq_ff;
      best_node_in = best_node_ff;
      best_idx_in  = best_idx_ff;
      push_want    = 1'b0;
      push_job     = '0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               id_in    = req_node_id;
               cnt_in   = req_patch_count;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               pz_in    = req_pos_z;
               dx_in    = {req_pos_x[POS_W-1], req_pos_x} - {qx_ff[POS_W-1], qx_ff};
               dy_in    = {req_pos_y[POS_W-1], req_pos_y} - {qy_ff[POS_W-1], qy_ff};
               dz_in    = {req_pos_z[POS_W-1], req_pos_z} - {qz_ff[POS_W-1], qz_ff};
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            sqx_in   = ax * ax;
            sqy_in   = ay * ay;
            sqz_in   = az * az;
            state_in = F_CMP;
         end
         F_CMP: begin
            if (kind_ff == KIND_QUERY) begin
               // new query, an empty patch answers at once
               push_want           = (cnt_sat == '0);
               push_job.query_id   = id_ff;
               push_job.best_node  = '0;
               push_job.dist_sq    = '0;
               push_job.not_found  = 1'b1;
               push_job.best_index = '0;
               push_job.count      = '0;
               if (!(push_want && queue_full)) begin
                  qnode_in     = id_ff;
                  qx_in        = px_ff;
                  qy_in        = py_ff;
                  qz_in        = pz_ff;
                  exp_in       = cnt_sat;
                  seen_in      = '0;
                  best_sq_in   = DSQ_ONES;
                  best_node_in = '0;
                  best_idx_in  = '0;
                  state_in     = F_IDLE;
               end
            end else begin
               // candidate, stray ones are dropped
               push_want           = active && (seen_nx == exp_ff);
               push_job.query_id   = qnode_ff;
               push_job.best_node  = nb_node;
               push_job.dist_sq    = nb_sq;
               push_job.not_found  = 1'b0;
               push_job.best_index = nb_idx;
               push_job.count      = exp_ff;
               if (!(push_want && queue_full)) begin
                  if (active) begin
                     best_sq_in   = nb_sq;
                     best_node_in = nb_node;
                     best_idx_in  = nb_idx;
                     seen_in      = seen_nx;
                  end
                  state_in = F_IDLE;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_valid = push_want && !queue_full;

   // control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         qnode_ff     <= '0;
         qx_ff        <= '0;
         qy_ff        <= '0;
         qz_ff        <= '0;
         exp_ff       <= '0;
         seen_ff      <= '0;
         best_sq_ff   <= DSQ_ONES;
         best_node_ff <= '0;
         best_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         qnode_ff     <= qnode_in;
         qx_ff        <= qx_in;
         qy_ff        <= qy_in;
         qz_ff        <= qz_in;
         exp_ff       <= exp_in;
         seen_ff      <= seen_in;
         best_sq_ff   <= best_sq_in;
         best_node_ff <= best_node_in;
         best_idx_ff  <= best_idx_in;
      end
   end

   // word and arithmetic registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      id_ff   <= id_in;
      cnt_ff  <= cnt_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      pz_ff   <= pz_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      sqz_ff  <= sqz_in;
   end

   // a found job always names a candidate inside a nonempty patch
   a_job_index: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_job.not_found) |->
         (push_job.count != '0 && push_job.best_index < push_job.count))
      else $error("job best index outside its patch");

   // an empty patch job carries no candidate
   a_empty_job: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_job.not_found) |-> (push_job.best_node == '0))
      else $error("empty patch job carries a candidate id");

   // the tracked patch never runs past its size
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= exp_ff)
      else $error("seen count exceeds patch size");

endmodule

FILE: src/npps_queue.sv
// short job queue between front and back
module npps_queue import npps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_job
);

   job_type            mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full job queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty job queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(Q_DEPTH))
      else $error("job queue fill count out of range");

endmodule

FILE: src/npps_back.sv
// back end: square root and index fraction per job, running maximum, result register
module npps_back import npps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  job_type pop_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output res_type rsp_res
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_DONE = 3'b100
   } bstate_type;

   bstate_type        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ID_W-1:0]   qid_ff, qid_in;
   logic [ID_W-1:0]   node_ff, node_in;
   logic              nf_ff, nf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DSQ_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;
   logic [CNT_W:0]    drem_ff, drem_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [FRAC_W-1:0] max_ff, max_in;
   logic              out_valid_ff, out_valid_in;
   res_type           out_ff, out_in;

   logic [REM_W-1:0]  rem_sh, trial;
   logic              rge;
   logic [CNT_W:0]    dsh;
   logic              dge;
   logic              load;
   logic [FRAC_W-1:0] new_max;

   // one root digit per cycle
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[DSQ_W-1:DSQ_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign rge    = rem_sh >= trial;

   // one quotient bit per cycle
   assign dsh = {drem_ff[CNT_W-1:0], 1'b0};
   assign dge = dsh >= {1'b0, cnt_ff};

   assign pop     = (state_ff == B_IDLE) && !queue_empty;
   assign load    = (state_ff == B_DONE) && (!out_valid_ff || rsp_ready);
   assign new_max = (!nf_ff && quo_ff > max_ff) ? quo_ff : max_ff;

   // job sequencing
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      qid_in       = qid_ff;
      node_in      = node_ff;
      nf_in        = nf_ff;
      cnt_in       = cnt_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      max_in       = max_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               qid_in   = pop_job.query_id;
               node_in  = pop_job.best_node;
               nf_in    = pop_job.not_found;
               cnt_in   = pop_job.count;
               rad_in   = pop_job.dist_sq;
               rem_in   = '0;
               root_in  = '0;
               drem_in  = {1'b0, pop_job.best_index};
               quo_in   = '0;
               step_in  = '0;
               state_in = pop_job.not_found ? B_DONE : B_RUN;
            end
         end
         B_RUN: begin
            rad_in  = {rad_ff[DSQ_W-3:0], 2'b00};
            rem_in  = rge ? (rem_sh - trial) : rem_sh;
            root_in = {root_ff[DIST_W-2:0], rge};
            if (step_ff < STEP_W'(FRAC_W)) begin
               drem_in = dge ? (dsh - {1'b0, cnt_ff}) : dsh;
               quo_in  = {quo_ff[FRAC_W-2:0], dge};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIST_W - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load) begin
               max_in              = new_max;
               out_valid_in        = 1'b1;
               out_in.query_id     = qid_ff;
               out_in.nearest_id   = nf_ff ? '0 : node_ff;
               out_in.distance     = nf_ff ? '0 : root_ff;
               out_in.status       = nf_ff ? ST_NOT_FOUND : ST_FOUND;
               out_in.max_fraction = new_max;
               state_in            = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // job and arithmetic registers
   always_ff @(posedge clock) begin
      qid_ff  <= qid_in;
      node_ff <= node_in;
      nf_ff   <= nf_in;
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;

   // the division remainder stays below the patch size
   a_drem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> (drem_ff < {1'b0, cnt_ff}))
      else $error("division remainder not below divisor");

   // a result word is only written when the previous one is gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // the running maximum never falls
   a_max_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (max_ff >= $past(max_ff)))
      else $error("running maximum decreased");

endmodule

FILE: sim/nearest_point_patch_search_test.sv
// testbench for the nearest point patch search block: directed and random patches, self checking
`timescale 1ns / 100ps

module nearest_point_patch_search_test;
   import npps_pkg::*;

   localparam int MAX_PATCH    = 1024;
   localparam int RANDOM_WORDS = 500;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AFTER   = 30;

   // one request word before packing
   typedef struct {
      logic                    kind;
      logic [ID_W-1:0]         node_id;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [CNT_W-1:0]        patch_count;
   } search_word_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} ready_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;  // node_id, pos_x, pos_y, pos_z, patch_count, zero pad
   logic         req_tuser = 1'b0;  // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;  // query_id, nearest_id, distance, status, max_fraction, pad

   search_word_type pending_words[$];
   res_type         nearest_answers[$];

   // predictor copy of the search state
   logic [ID_W-1:0]         cur_query_id = '0;
   logic signed [POS_W-1:0] cur_qx = '0;
   logic signed [POS_W-1:0] cur_qy = '0;
   logic signed [POS_W-1:0] cur_qz = '0;
   logic [CNT_W-1:0]        patch_size = '0;
   logic [CNT_W-1:0]        cands_seen = '0;
   logic [DSQ_W-1:0]        best_dsq = DSQ_ONES;
   logic [ID_W-1:0]         best_id = '0;
   logic [CNT_W-1:0]        best_idx = '0;
   logic [FRAC_W-1:0]       max_frac = '0;

   int words_taken   = 0;
   int queries_taken = 0;
   int results_seen  = 0;
   int empty_results = 0;
   int mismatches    = 0;
   int idle_cycles   = 0;
   int burst_left    = 0;
   int gap_left      = 0;
   int mode_left     = 0;
   int hold_left     = 0;
   int hold_seen     = 0;
   logic hold_done   = 1'b0;
   ready_mode_type ready_mode = RDY_ALWAYS;

   nearest_point_patch_search #(.MAX_PATCH(MAX_PATCH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // floor square root, one result bit at a time
   function automatic logic [DIST_W-1:0] floor_root(input logic [DSQ_W-1:0] v);
      logic [DIST_W-1:0] r;
      logic [DIST_W-1:0] t;
      logic [DSQ_W-1:0]  sq;
      r = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
         t = r | (DIST_W'(1) << b);
         sq = DSQ_W'(t) * DSQ_W'(t);
         if (sq <= v) r = t;
      end
      return r;
   endfunction

   // advance the search state by one accepted word, queue any answer it yields
   function automatic void search_step(input search_word_type w);
      res_type           ans;
      longint            dx;
      longint            dy;
      longint            dz;
      logic [DSQ_W-1:0]  dsq;
      longint unsigned   frac;
      if (w.kind == KIND_QUERY) begin
         cur_query_id = w.node_id;
         cur_qx = w.pos_x;
         cur_qy = w.pos_y;
         cur_qz = w.pos_z;
         patch_size = (w.patch_count > MAX_PATCH) ? CNT_W'(MAX_PATCH) : w.patch_count;
         cands_seen = '0;
         best_dsq = DSQ_ONES;
         best_id = '0;
         best_idx = '0;
         if (patch_size == 0) begin
            ans.query_id = cur_query_id;
            ans.nearest_id = '0;
            ans.distance = '0;
            ans.status = ST_NOT_FOUND;
            ans.max_fraction = max_frac;
            nearest_answers.push_back(ans);
         end
         return;
      end
      // stray candidate with no open patch
      if (cands_seen >= patch_size) return;
      dx = longint'(w.pos_x) - longint'(cur_qx);
      dy = longint'(w.pos_y) - longint'(cur_qy);
      dz = longint'(w.pos_z) - longint'(cur_qz);
      dsq = DSQ_W'(dx * dx + dy * dy + dz * dz);
      // strictly smaller only, so the earlier candidate keeps a tie
      if (dsq < best_dsq) begin
         best_dsq = dsq;
         best_id = w.node_id;
         best_idx = cands_seen;
      end
      cands_seen = cands_seen + 1'b1;
      if (cands_seen < patch_size) return;
      frac = (64'(best_idx) << 16) / 64'(patch_size);
      if (frac > 64'hFFFF) frac = 64'hFFFF;
      if (frac > max_frac) max_frac = FRAC_W'(frac);
      ans.query_id = cur_query_id;
      ans.nearest_id = best_id;
      ans.distance = floor_root(best_dsq);
      ans.status = ST_FOUND;
      ans.max_fraction = max_frac;
      nearest_answers.push_back(ans);
   endfunction

   task automatic add_word(input logic kind, input logic [ID_W-1:0] id,
                           input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                           input logic signed [POS_W-1:0] z, input logic [CNT_W-1:0] cnt);
      search_word_type w;
      w.kind = kind;
      w.node_id = id;
      w.pos_x = x;
      w.pos_y = y;
      w.pos_z = z;
      w.patch_count = cnt;
      pending_words.push_back(w);
   endtask

   function automatic logic signed [POS_W-1:0] rand_coord();
      return POS_W'($urandom);
   endfunction

   // a coordinate close to a center, wrapping at the range ends
   function automatic logic signed [POS_W-1:0] near_coord(input logic signed [POS_W-1:0] c);
      return c + POS_W'($urandom_range(0, 511)) - POS_W'(256);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %0s at result %0d: got %0h, want %0h",
               what, results_seen, got, want);
      mismatches++;
   endtask

   // stimulus, reset and end of run
   initial begin
      int random_words;
      int pick;
      int n;
      int cut;
      logic signed [POS_W-1:0] qx, qy, qz, cx, cy, cz;
      logic [ID_W-1:0] qid;

      // stray candidate right after reset
      add_word(KIND_CAND, 32'hFFFF_FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 11'h7FF);
      // empty patch, then a stray candidate after it
      add_word(KIND_QUERY, 32'h0, '0, '0, '0, 11'd0);
      add_word(KIND_CAND, 32'h5, 20'sd1, 20'sd2, 20'sd3, 11'd0);
      // negative extreme query: far candidate, then two at distance zero (tie)
      add_word(KIND_QUERY, 32'hFFFF_FFFF, -20'sh80000, -20'sh80000, -20'sh80000, 11'd3);
      add_word(KIND_CAND, 32'd1, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 11'd0);
      add_word(KIND_CAND, 32'd2, -20'sh80000, -20'sh80000, -20'sh80000, 11'd0);
      add_word(KIND_CAND, 32'd3, -20'sh80000, -20'sh80000, -20'sh80000, 11'd0);
      // stray candidate after a finished patch
      add_word(KIND_CAND, 32'd4, 20'sd0, 20'sd0, 20'sd0, 11'd5);
      // query cut short by the next query, with a tie on distance 5
      add_word(KIND_QUERY, 32'hA5A5_0001, '0, '0, '0, 11'd4);
      add_word(KIND_CAND, 32'd10, 20'sd3, 20'sd4, 20'sd0, 11'd0);
      add_word(KIND_CAND, 32'd11, 20'sd0, 20'sd0, -20'sd5, 11'd0);
      add_word(KIND_CAND, 32'd12, 20'sd5, 20'sd0, 20'sd0, 11'd0);
      add_word(KIND_QUERY, 32'h5A5A_0002, 20'sd100, -20'sd100, 20'sd7, 11'd2);
      add_word(KIND_CAND, 32'd20, 20'sd300, -20'sd100, 20'sd7, 11'd0);
      add_word(KIND_CAND, 32'd21, 20'sd101, -20'sd99, 20'sd7, 11'd0);
      // positive extreme query against the far corner
      add_word(KIND_QUERY, 32'h8000_0000, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 11'd1);
      add_word(KIND_CAND, 32'h7FFF_FFFF, -20'sh80000, -20'sh80000, -20'sh80000, 11'd0);

      // oversized count saturates to the largest patch; nearest comes last
      qid = $urandom;
      qx = rand_coord();
      qy = rand_coord();
      qz = rand_coord();
      add_word(KIND_QUERY, qid, qx, qy, qz, 11'h7FF);
      for (int k = 0; k < MAX_PATCH - 1; k++)
         add_word(KIND_CAND, $urandom, rand_coord(), rand_coord(), rand_coord(), CNT_W'($urandom));
      add_word(KIND_CAND, $urandom, qx, qy, qz, CNT_W'($urandom));

      // random patches: mostly complete, some empty, some cut short, a few strays
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            add_word(KIND_CAND, $urandom, rand_coord(), rand_coord(), rand_coord(),
                     CNT_W'($urandom));
         end else begin
            if (pick < 10) n = 0;
            else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 40);
            else n = $urandom_range(1, 8);
            cut = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
            qx = rand_coord();
            qy = rand_coord();
            qz = rand_coord();
            add_word(KIND_QUERY, $urandom, qx, qy, qz, CNT_W'(n));
            random_words++;
            cx = qx;
            cy = qy;
            cz = qz;
            for (int k = 0; k < cut; k++) begin
               // repeat the last point now and then to force ties
               if (k == 0 || $urandom_range(0, 4) != 0) begin
                  if ($urandom_range(0, 1) == 0) begin
                     cx = near_coord(qx);
                     cy = near_coord(qy);
                     cz = near_coord(qz);
                  end else begin
                     cx = rand_coord();
                     cy = rand_coord();
                     cz = rand_coord();
                  end
               end
               add_word(KIND_CAND, $urandom, cx, cy, cz, CNT_W'($urandom));
               random_words++;
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      while (nearest_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request words (%0d queries) and %0d result words,",
               words_taken, queries_taken, results_seen);
      $display("%0d of them empty patches; final running max fraction %0h",
               empty_results, max_frac);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // request driver: bursts of words with random gaps
   always @(posedge clock) begin : drive_words
      logic fire;
      fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (fire) begin
            search_step(pending_words[0]);
            if (pending_words[0].kind == KIND_QUERY) queries_taken++;
            pending_words.pop_front();
            words_taken++;
         end
         if (req_tvalid && !fire) begin
            // hold the word until it is taken
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_words[0].kind;
            req_tdata <= {1'b0, pending_words[0].patch_count, pending_words[0].pos_z,
                          pending_words[0].pos_y, pending_words[0].pos_x,
                          pending_words[0].node_id};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // one long receiver hold-off once some results have been taken
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) hold_seen <= hold_seen + 1;
         if (!hold_done && hold_seen == HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // result receiver: stall pattern switches between modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left <= 0;
         ready_mode <= RDY_ALWAYS;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               RDY_ALWAYS: rsp_tready <= 1'b1;
               RDY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 0);
               RDY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:    rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // result monitor: compare each word with the oldest expected answer
   always @(posedge clock) begin : check_results
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (nearest_answers.size() == 0) begin
            report_mismatch("unexpected result word", 64'(rsp_tdata[31:0]), 64'h0);
         end else begin
            want = nearest_answers.pop_front();
            if (want.status == ST_NOT_FOUND) empty_results++;
            if (rsp_tdata[31:0] != want.query_id)
               report_mismatch("query_id", 64'(rsp_tdata[31:0]), 64'(want.query_id));
            if (rsp_tdata[63:32] != want.nearest_id)
               report_mismatch("nearest_id", 64'(rsp_tdata[63:32]), 64'(want.nearest_id));
            if (rsp_tdata[84:64] != want.distance)
               report_mismatch("distance", 64'(rsp_tdata[84:64]), 64'(want.distance));
            if (rsp_tdata[85] != want.status)
               report_mismatch("status", 64'(rsp_tdata[85]), 64'(want.status));
            if (rsp_tdata[101:86] != want.max_fraction)
               report_mismatch("max_fraction", 64'(rsp_tdata[101:86]),
                               64'(want.max_fraction));
         end
         results_seen++;
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("no word moved for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
